@@ rtl/cham128_pkg.sv @@
package cham128_pkg;

	localparam int unsigned ROUND_KEY_COUNT = 16;
	localparam int unsigned WORD_W          = 32;
	localparam int unsigned ROUND_W         = 7;
	localparam int unsigned ROUNDS_128      = 80;
	localparam int unsigned ROUNDS_256      = 96;
	localparam int unsigned CFG_INDEX_W     = 3;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned BLOCK_W         = 128;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_SIZE_256 = 3'd0,
		REG_KEY_0_7      = 3'd1,
		REG_KEY_8_15     = 3'd2,
		REG_KEY_16_23    = 3'd3,
		REG_KEY_24_31    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	function automatic word_t rotl32(input word_t v, input int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	function automatic word_t rotr32(input word_t v, input int unsigned s);
		return (v >> s) | (v << (WORD_W - s));
	endfunction

endpackage

@@ rtl/cham128_block_cipher_core.sv @@
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: block_high, block_low; s_tuser: func
// m_*      out  m_tvalid/m_tready  m_tdata: result_high, result_low
// cfg_*    in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One round per cycle through a single shared add/subtract round unit: an accepted beat
// is followed by 80 rounds (128-bit key) or 96 rounds (256-bit key), then the drain state
// hands the block to the output register once it is free, and only after that hand-over
// is the next beat taken. The round key table is registered from the key registers and
// follows a write in the cycle after the key registers take it.
// The output register holds a result until m_tready; a new block is taken
// meanwhile, and only its hand-over waits. arst_n clears control and keys.
module cham128_block_cipher_core #(
	parameter int unsigned ROUND_KEY_COUNT = cham128_pkg::ROUND_KEY_COUNT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [63:0] block_high, [127:64] block_low
	input  logic [cham128_pkg::BLOCK_W-1:0]      s_tdata,
	// [0] func
	input  logic [0:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [63:0] result_high, [127:64] result_low
	output logic [cham128_pkg::BLOCK_W-1:0]      m_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [cham128_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cham128_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int unsigned RK_IDX_W = $clog2(ROUND_KEY_COUNT);
	localparam int unsigned W        = cham128_pkg::WORD_W;
	localparam int unsigned RW       = cham128_pkg::ROUND_W;

	cham128_pkg::state_t state_q, state_d;

	logic                             ks256_q;
	logic [cham128_pkg::CFG_DATA_W-1:0] key_q [4];
	cham128_pkg::word_t               tbl_q [ROUND_KEY_COUNT];
	cham128_pkg::word_t               tbl_d [ROUND_KEY_COUNT];

	cham128_pkg::word_t               x_q [4];
	logic                             dec_q;
	logic [RW-1:0]                    rnd_q;
	logic [cham128_pkg::BLOCK_W-1:0]  out_q;
	logic                             out_vld_q;

	logic                             accept;
	logic                             out_free;
	logic                             last_round;
	logic                             load_out;
	logic [RW-1:0]                    last_rnd;

	logic [4:0]                       rk_m;
	logic [4:0]                       rk_r;
	logic [RK_IDX_W-1:0]              rk_idx;
	cham128_pkg::word_t               rk;
	cham128_pkg::word_t               rnd_w;
	cham128_pkg::word_t               op_a;
	cham128_pkg::word_t               op_b;
	cham128_pkg::word_t               op_bx;
	cham128_pkg::word_t               sum;
	cham128_pkg::word_t               rnd_out;

	// key schedule
	always_comb begin
		cham128_pkg::word_t k;
		cham128_pkg::word_t f1;
		cham128_pkg::word_t f2;
		tbl_d = '{default: '0};
		for (int j = 0; j < 8; j++) begin
			k  = (j % 2 == 0) ? key_q[2'(j/2)][63:32] : key_q[2'(j/2)][31:0];
			f1 = k ^ cham128_pkg::rotl32(k, 1) ^ cham128_pkg::rotl32(k, 8);
			f2 = k ^ cham128_pkg::rotl32(k, 1) ^ cham128_pkg::rotl32(k, 11);
			if (ks256_q) begin
				tbl_d[RK_IDX_W'(j % ROUND_KEY_COUNT)] = f1;
				tbl_d[RK_IDX_W'(((j + 8) ^ 1) % ROUND_KEY_COUNT)] = f2;
			end else if (j < 4) begin
				tbl_d[RK_IDX_W'(j % ROUND_KEY_COUNT)] = f1;
				tbl_d[RK_IDX_W'(((j + 4) ^ 1) % ROUND_KEY_COUNT)] = f2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks256_q <= 1'b0;
			key_q   <= '{default: '0};
			tbl_q   <= '{default: '0};
		end else begin
			tbl_q <= tbl_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					cham128_pkg::REG_KEY_SIZE_256: ks256_q  <= cfg_wdata[0];
					cham128_pkg::REG_KEY_0_7:      key_q[0] <= cfg_wdata;
					cham128_pkg::REG_KEY_8_15:     key_q[1] <= cfg_wdata;
					cham128_pkg::REG_KEY_16_23:    key_q[2] <= cfg_wdata;
					cham128_pkg::REG_KEY_24_31:    key_q[3] <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// shared round unit
	always_comb begin
		rk_m   = ks256_q ? {1'b0, rnd_q[3:0]} : {2'b00, rnd_q[2:0]};
		rk_r   = (rk_m >= 5'(ROUND_KEY_COUNT)) ? rk_m - 5'(ROUND_KEY_COUNT) : rk_m;
		rk_idx = rk_r[RK_IDX_W-1:0];
		rk     = tbl_q[rk_idx];
		rnd_w  = {{(W-RW){1'b0}}, rnd_q};

		if (dec_q) begin
			op_a = rnd_q[0] ? cham128_pkg::rotr32(x_q[3], 1) : cham128_pkg::rotr32(x_q[3], 8);
			op_b = (rnd_q[0] ? cham128_pkg::rotl32(x_q[0], 8)
			                 : cham128_pkg::rotl32(x_q[0], 1)) ^ rk;
		end else begin
			op_a = x_q[0] ^ rnd_w;
			op_b = (rnd_q[0] ? cham128_pkg::rotl32(x_q[1], 8)
			                 : cham128_pkg::rotl32(x_q[1], 1)) ^ rk;
		end
		op_bx = dec_q ? ~op_b : op_b;
		sum   = op_a + op_bx + {{(W-1){1'b0}}, dec_q};

		if (dec_q) begin
			rnd_out = sum ^ rnd_w;
		end else begin
			rnd_out = rnd_q[0] ? cham128_pkg::rotl32(sum, 1) : cham128_pkg::rotl32(sum, 8);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cham128_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		last_rnd   = ks256_q ? RW'(cham128_pkg::ROUNDS_256 - 1) : RW'(cham128_pkg::ROUNDS_128 - 1);
		last_round = dec_q ? (rnd_q == '0) : (rnd_q == last_rnd);
		out_free   = !out_vld_q || m_tready;
		s_tready   = 1'b0;
		load_out   = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			cham128_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = cham128_pkg::ST_RUN;
				end
			end
			cham128_pkg::ST_RUN: begin
				if (last_round) begin
					state_d = cham128_pkg::ST_DRAIN;
				end
			end
			cham128_pkg::ST_DRAIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = cham128_pkg::ST_IDLE;
				end
			end
			default: state_d = cham128_pkg::ST_IDLE;
		endcase
		accept = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= 1'b0;
			rnd_q <= '0;
		end else if (accept) begin
			dec_q <= s_tuser[0];
			rnd_q <= s_tuser[0] ? last_rnd : '0;
		end else if (state_q == cham128_pkg::ST_RUN) begin
			rnd_q <= dec_q ? rnd_q - RW'(1) : rnd_q + RW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q[0] <= s_tdata[63:32];
			x_q[1] <= s_tdata[31:0];
			x_q[2] <= s_tdata[127:96];
			x_q[3] <= s_tdata[95:64];
		end else if (state_q == cham128_pkg::ST_RUN) begin
			if (dec_q) begin
				x_q[0] <= rnd_out;
				x_q[1] <= x_q[0];
				x_q[2] <= x_q[1];
				x_q[3] <= x_q[2];
			end else begin
				x_q[0] <= x_q[1];
				x_q[1] <= x_q[2];
				x_q[2] <= x_q[3];
				x_q[3] <= rnd_out;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= {x_q[2], x_q[3], x_q[0], x_q[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule
